### hdl/bitmap_frame_allocator_unit_macros.svh
// assertion macros for the bitmap frame allocator
// included by files that carry concurrent checks, no other dependencies
`ifndef BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, checks are off during reset
`define BFA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bitmap frame allocator check failed");

// next-cycle implication, checks are off during reset
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bitmap frame allocator check failed");

`endif

### hdl/bfa_pkg.sv
// shared types, sizes and helper functions of the bitmap frame allocator
// no dependencies
package bfa_pkg;

  localparam int BITMAP_WORDS = 1024;
  localparam int PAGE_SHIFT   = 12;
  localparam int WORD_BITS    = 32;
  localparam int BIT_AW       = 5;
  localparam int WORD_AW      = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int SUM_WORDS    = (BITMAP_WORDS + WORD_BITS - 1) / WORD_BITS;
  localparam int SUM_AW       = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
  localparam int FRAME_W      = 32 - PAGE_SHIFT;
  localparam int NUM_FRAMES   = BITMAP_WORDS * WORD_BITS;
  localparam int CNT_W        = WORD_AW + 1;

  localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_MARK   = 3'd2,
    OP_REGION = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_USED    = 2'd1,
    ST_NOFRAME = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_WR,
    S_RMW,
    S_REG_W,
    S_REG_S_RD,
    S_REG_S_WR,
    S_FINISH
  } state_t;

  // index of the lowest clear bit, zero when there is none
  function automatic logic [BIT_AW-1:0] first_zero(input logic [WORD_BITS-1:0] word);
    logic [BIT_AW-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) idx = BIT_AW'(i);
    end
    return idx;
  endfunction

  // summary group that holds a bitmap word
  function automatic logic [SUM_AW-1:0] word_grp(input logic [WORD_AW-1:0] w);
    return SUM_AW'(w >> BIT_AW);
  endfunction

  // summary contents after a clear: words past the end count as full
  function automatic logic [WORD_BITS-1:0] sum_init(input logic [SUM_AW-1:0] s);
    logic [WORD_BITS-1:0] v;
    for (int j = 0; j < WORD_BITS; j++) begin
      v[j] = ((int'(s) * WORD_BITS + j) >= BITMAP_WORDS);
    end
    return v;
  endfunction

endpackage

### hdl/bitmap_frame_allocator_unit.sv
// Page frame allocator over a used/free bitmap, one bit per frame, 1024 words of 32 frames.
// The bitmap sits in one memory and a second memory holds one full flag per bitmap word, with
// a 32-bit register of full flags over the summary words, so allocate reaches the lowest free
// frame in three reads and no word walk. Free and mark-at read and update the frame's words, an
// unknown code or a rejected request goes straight to the result, and mark-region fills each
// 32-frame word spanned, then updates the summary words they fall in. Clear and the same pass
// after reset write one bitmap word per cycle, and no item is taken during the pass. One item
// is worked on at a time; the result sits in an output register so the next item is accepted
// while it waits to be taken.
`include "bitmap_frame_allocator_unit_macros.svh"

module bitmap_frame_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [31:0] address,
  input  logic [31:0] end_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] frame_address,
  output logic [1:0]  status
);

  localparam int WA = bfa_pkg::WORD_AW;
  localparam int SA = bfa_pkg::SUM_AW;
  localparam int BA = bfa_pkg::BIT_AW;

  bfa_pkg::state_t state, state_next;

  // memories
  logic [31:0] bm_mem [bfa_pkg::BITMAP_WORDS];
  logic [31:0] sm_mem [bfa_pkg::SUM_WORDS];
  logic          bm_we, sm_we;
  logic [WA-1:0] bm_waddr, bm_raddr;
  logic [SA-1:0] sm_waddr, sm_raddr;
  logic [31:0]   bm_wdata, sm_wdata, bm_rdata, sm_rdata;

  // full flag per summary word
  logic [bfa_pkg::SUM_WORDS-1:0] top;
  logic          top_we, top_val, top_clr;
  logic [SA-1:0] top_idx, top_pick;
  logic          top_all;

  // datapath registers
  logic [WA-1:0]        w_reg, g0_reg, g1_reg;
  logic [SA-1:0]        s_reg;
  logic [BA-1:0]        bit_reg;
  logic [2:0]           op_reg;
  logic [31:0]          sum_reg;
  logic [31:0]          res_addr;
  bfa_pkg::status_t     res_status;
  logic [WA-1:0]        clr_cnt;
  logic                 reply;

  // input decode
  logic [bfa_pkg::FRAME_W-1:0] in_frame, end_frame;
  logic                        in_ok, end_ok;
  logic [WA-1:0]               in_word, end_word;
  logic [BA-1:0]               in_bit;
  logic                        accept, out_free;
  bfa_pkg::status_t            acc_status;

  // working values
  logic [BA-1:0] alloc_j, alloc_b;
  logic [31:0]   word_new, sum_new, reg_mask;
  logic [BA-1:0] reg_lo, reg_hi;

  assign in_frame  = address[31:bfa_pkg::PAGE_SHIFT];
  assign end_frame = end_address[31:bfa_pkg::PAGE_SHIFT];
  assign in_ok     = 33'(in_frame) < 33'(bfa_pkg::NUM_FRAMES);
  assign end_ok    = 33'(end_frame) < 33'(bfa_pkg::NUM_FRAMES);
  assign in_word   = WA'(in_frame >> BA);
  assign end_word  = WA'(end_frame >> BA);
  assign in_bit    = in_frame[BA-1:0];

  assign in_ready = (state == bfa_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    top_pick = '0;
    for (int i = bfa_pkg::SUM_WORDS - 1; i >= 0; i--) begin
      if (!top[i]) top_pick = SA'(i);
    end
  end
  assign top_all = &top;

  assign alloc_j = bfa_pkg::first_zero(sm_rdata);
  assign alloc_b = bfa_pkg::first_zero(bm_rdata);

  // summary bits covered by the region within the current summary word
  assign reg_lo   = (s_reg == bfa_pkg::word_grp(g0_reg)) ? g0_reg[BA-1:0] : '0;
  assign reg_hi   = (s_reg == bfa_pkg::word_grp(g1_reg)) ? g1_reg[BA-1:0] : '1;
  assign reg_mask = (bfa_pkg::FULL_WORD << reg_lo) & (bfa_pkg::FULL_WORD >> (5'd31 - reg_hi));

  always_comb begin
    acc_status = bfa_pkg::ST_OK;
    case (opcode)
      bfa_pkg::OP_ALLOC:  if (top_all) acc_status = bfa_pkg::ST_NOFRAME;
      bfa_pkg::OP_FREE,
      bfa_pkg::OP_MARK:   if (!in_ok) acc_status = bfa_pkg::ST_RANGE;
      bfa_pkg::OP_REGION: if (!in_ok || !end_ok) acc_status = bfa_pkg::ST_RANGE;
      default:            acc_status = bfa_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bfa_pkg::S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    bm_we      = 1'b0;
    bm_waddr   = w_reg;
    bm_wdata   = '0;
    bm_raddr   = in_word;
    sm_we      = 1'b0;
    sm_waddr   = s_reg;
    sm_wdata   = '0;
    sm_raddr   = (opcode == bfa_pkg::OP_ALLOC) ? top_pick : bfa_pkg::word_grp(in_word);
    top_we     = 1'b0;
    top_idx    = s_reg;
    top_val    = 1'b0;
    top_clr    = 1'b0;
    word_new   = '0;
    sum_new    = '0;
    case (state)
      bfa_pkg::S_CLEAR: begin
        top_clr  = 1'b1;
        bm_we    = 1'b1;
        bm_waddr = clr_cnt;
        sm_waddr = SA'(clr_cnt);
        sm_wdata = bfa_pkg::sum_init(SA'(clr_cnt));
        sm_we    = {1'b0, clr_cnt} < bfa_pkg::CNT_W'(bfa_pkg::SUM_WORDS);
        if (clr_cnt == WA'(bfa_pkg::BITMAP_WORDS - 1)) begin
          state_next = reply ? bfa_pkg::S_FINISH : bfa_pkg::S_IDLE;
        end
      end
      bfa_pkg::S_IDLE: begin
        if (accept) begin
          state_next = bfa_pkg::S_FINISH;
          case (opcode)
            bfa_pkg::OP_ALLOC:  if (!top_all) state_next = bfa_pkg::S_ALLOC_RD;
            bfa_pkg::OP_FREE,
            bfa_pkg::OP_MARK:   if (in_ok) state_next = bfa_pkg::S_RMW;
            bfa_pkg::OP_REGION: begin
              if (in_ok && end_ok && in_word <= end_word) state_next = bfa_pkg::S_REG_W;
            end
            bfa_pkg::OP_CLEAR:  state_next = bfa_pkg::S_CLEAR;
            default:            state_next = bfa_pkg::S_FINISH;
          endcase
        end
      end
      bfa_pkg::S_ALLOC_RD: begin
        // summary word is back: pick the first bitmap word with room
        bm_raddr   = WA'({s_reg, alloc_j});
        state_next = bfa_pkg::S_ALLOC_WR;
      end
      bfa_pkg::S_ALLOC_WR: begin
        word_new   = bm_rdata | (32'd1 << alloc_b);
        sum_new    = sum_reg | (32'(word_new == bfa_pkg::FULL_WORD) << w_reg[BA-1:0]);
        bm_we      = 1'b1;
        bm_wdata   = word_new;
        sm_we      = 1'b1;
        sm_wdata   = sum_new;
        top_we     = 1'b1;
        top_val    = (sum_new == bfa_pkg::FULL_WORD);
        state_next = bfa_pkg::S_FINISH;
      end
      bfa_pkg::S_RMW: begin
        if (op_reg == bfa_pkg::OP_FREE) begin
          word_new = bm_rdata & ~(32'd1 << bit_reg);
          sum_new  = sm_rdata & ~(32'd1 << w_reg[BA-1:0]);
          bm_we    = 1'b1;
          sm_we    = 1'b1;
          top_we   = 1'b1;
        end else begin
          word_new = bm_rdata | (32'd1 << bit_reg);
          sum_new  = sm_rdata | (32'(word_new == bfa_pkg::FULL_WORD) << w_reg[BA-1:0]);
          bm_we    = !bm_rdata[bit_reg];
          sm_we    = !bm_rdata[bit_reg];
          top_we   = !bm_rdata[bit_reg];
        end
        bm_wdata   = word_new;
        sm_wdata   = sum_new;
        top_val    = (sum_new == bfa_pkg::FULL_WORD);
        state_next = bfa_pkg::S_FINISH;
      end
      bfa_pkg::S_REG_W: begin
        bm_we    = 1'b1;
        bm_wdata = bfa_pkg::FULL_WORD;
        if (w_reg == g1_reg) state_next = bfa_pkg::S_REG_S_RD;
      end
      bfa_pkg::S_REG_S_RD: begin
        sm_raddr   = s_reg;
        state_next = bfa_pkg::S_REG_S_WR;
      end
      bfa_pkg::S_REG_S_WR: begin
        sum_new  = sm_rdata | reg_mask;
        sm_we    = 1'b1;
        sm_wdata = sum_new;
        top_we   = 1'b1;
        top_val  = (sum_new == bfa_pkg::FULL_WORD);
        if (s_reg == bfa_pkg::word_grp(g1_reg)) state_next = bfa_pkg::S_FINISH;
        else                                    state_next = bfa_pkg::S_REG_S_RD;
      end
      bfa_pkg::S_FINISH: begin
        if (out_free) state_next = bfa_pkg::S_IDLE;
      end
      default: state_next = bfa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    bm_rdata <= bm_mem[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (sm_we) sm_mem[sm_waddr] <= sm_wdata;
    sm_rdata <= sm_mem[sm_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top <= '0;
    end else if (top_clr) begin
      top <= '0;
    end else if (top_we) begin
      top[top_idx] <= top_val;
    end
  end

  // control counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt   <= '0;
      reply     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == bfa_pkg::S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      else                           clr_cnt <= '0;
      if (accept) reply <= 1'b1;
      if (state == bfa_pkg::S_FINISH && out_free) out_valid <= 1'b1;
      else if (out_ready)                           out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      bfa_pkg::S_IDLE: begin
        if (accept) begin
          op_reg     <= opcode;
          res_addr   <= '0;
          res_status <= acc_status;
          w_reg      <= in_word;
          g0_reg     <= in_word;
          g1_reg     <= end_word;
          bit_reg    <= in_bit;
          s_reg      <= (opcode == bfa_pkg::OP_ALLOC) ? top_pick : bfa_pkg::word_grp(in_word);
        end
      end
      bfa_pkg::S_ALLOC_RD: begin
        w_reg   <= WA'({s_reg, alloc_j});
        sum_reg <= sm_rdata;
      end
      bfa_pkg::S_ALLOC_WR: begin
        res_addr <= 32'({w_reg, alloc_b}) << bfa_pkg::PAGE_SHIFT;
      end
      bfa_pkg::S_RMW: begin
        if (op_reg == bfa_pkg::OP_MARK && bm_rdata[bit_reg]) res_status <= bfa_pkg::ST_USED;
      end
      bfa_pkg::S_REG_W: begin
        w_reg <= w_reg + 1'b1;
        if (w_reg == g1_reg) s_reg <= bfa_pkg::word_grp(g0_reg);
      end
      bfa_pkg::S_REG_S_WR: begin
        s_reg <= s_reg + 1'b1;
      end
      bfa_pkg::S_FINISH: begin
        if (out_free) begin
          frame_address <= res_addr;
          status        <= res_status;
        end
      end
      default: ;
    endcase
  end

  // a word picked through the full flags must have a free bit
  `BFA_ASSERT_NOW(a_alloc_room, clk, rst, state == bfa_pkg::S_ALLOC_WR, bm_rdata != bfa_pkg::FULL_WORD)
  // only a successful allocate gives an address
  `BFA_ASSERT_NOW(a_addr_zero, clk, rst, out_valid && status != bfa_pkg::ST_OK, frame_address == 32'd0)
  // one item in flight at a time
  `BFA_ASSERT_NEXT(a_one_item, clk, rst, accept, !in_ready)
  // the clearing pass leaves every summary word free of full flags
  `BFA_ASSERT_NEXT(a_clear_top, clk, rst, state == bfa_pkg::S_CLEAR, top == '0)

endmodule

### bench/tb_bitmap_frame_allocator_unit.sv
// self-checking bench for the bitmap page frame allocator: directed and random items
// with a bitmap predictor held in a small scoreboard class; depends on bfa_pkg and the rtl
module tb_bitmap_frame_allocator_unit;

  localparam int FRAME_BYTES = 1 << bfa_pkg::PAGE_SHIFT;
  localparam logic [31:0] GROUP_BYTES = 32'(bfa_pkg::WORD_BITS) << bfa_pkg::PAGE_SHIFT;
  localparam logic [31:0] LAST_ADDR =
    32'((64'(bfa_pkg::NUM_FRAMES) << bfa_pkg::PAGE_SHIFT) - 64'd1);
  localparam int OPCODE_CODES = 8;
  localparam int RANDOM_ITEMS = 750;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 50;

  typedef struct {
    logic [31:0]      frame_address;
    bfa_pkg::status_t status;
  } alloc_reply_t;

  class frame_alloc_scoreboard;
    logic [bfa_pkg::WORD_BITS-1:0] used_map [bfa_pkg::BITMAP_WORDS];
    alloc_reply_t awaited[$];
    int mismatches;

    function new();
      foreach (used_map[i]) used_map[i] = '0;
      mismatches = 0;
    endfunction

    // works out the reply to an accepted item and updates the frame map
    function void note_request(logic [2:0] op, logic [31:0] addr, logic [31:0] end_addr);
      alloc_reply_t r;
      logic [31:0] frame, frame_end;
      int w, b;
      bit found;
      r.frame_address = '0;
      r.status = bfa_pkg::ST_OK;
      frame = addr >> bfa_pkg::PAGE_SHIFT;
      frame_end = end_addr >> bfa_pkg::PAGE_SHIFT;
      case (op)
        bfa_pkg::OP_ALLOC: begin
          found = 1'b0;
          for (w = 0; w < bfa_pkg::BITMAP_WORDS && !found; w++) begin
            if (used_map[w] != bfa_pkg::FULL_WORD) begin
              for (b = 0; b < bfa_pkg::WORD_BITS && !found; b++) begin
                if (!used_map[w][b]) begin
                  used_map[w][b] = 1'b1;
                  r.frame_address =
                    32'((64'(w) * bfa_pkg::WORD_BITS + b) << bfa_pkg::PAGE_SHIFT);
                  found = 1'b1;
                end
              end
            end
          end
          if (!found) r.status = bfa_pkg::ST_NOFRAME;
        end
        bfa_pkg::OP_FREE: begin
          if (frame >= bfa_pkg::NUM_FRAMES) r.status = bfa_pkg::ST_RANGE;
          else used_map[frame / bfa_pkg::WORD_BITS][frame % bfa_pkg::WORD_BITS] = 1'b0;
        end
        bfa_pkg::OP_MARK: begin
          if (frame >= bfa_pkg::NUM_FRAMES) r.status = bfa_pkg::ST_RANGE;
          else if (used_map[frame / bfa_pkg::WORD_BITS][frame % bfa_pkg::WORD_BITS])
            r.status = bfa_pkg::ST_USED;
          else used_map[frame / bfa_pkg::WORD_BITS][frame % bfa_pkg::WORD_BITS] = 1'b1;
        end
        bfa_pkg::OP_REGION: begin
          if (frame >= bfa_pkg::NUM_FRAMES || frame_end >= bfa_pkg::NUM_FRAMES) begin
            r.status = bfa_pkg::ST_RANGE;
          end else begin
            // a reversed region leaves the loop empty
            for (w = int'(frame / bfa_pkg::WORD_BITS);
                 w <= int'(frame_end / bfa_pkg::WORD_BITS); w++)
              used_map[w] = bfa_pkg::FULL_WORD;
          end
        end
        bfa_pkg::OP_CLEAR: begin
          foreach (used_map[i]) used_map[i] = '0;
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    function void check_reply(logic [31:0] fa, logic [1:0] st);
      alloc_reply_t r;
      if (awaited.size() == 0) begin
        $error("result with no item waiting: frame_address %h status %0d", fa, st);
        mismatches++;
        return;
      end
      r = awaited.pop_front();
      if (fa !== r.frame_address) begin
        $error("frame_address: expected %h, actual %h", r.frame_address, fa);
        mismatches++;
      end
      if (st !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, st);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  opcode = '0;
  logic [31:0] address = '0;
  logic [31:0] end_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] frame_address;
  logic [1:0]  status;

  frame_alloc_scoreboard allocs;
  int items_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit rx_burst = 1'b0;
  bit tx_burst = 1'b0;

  bitmap_frame_allocator_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .address       (address),
    .end_address   (end_address),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_address (frame_address),
    .status        (status)
  );

  always #4 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // addresses cluster in the low frames so that allocate, free and mark meet
  function automatic logic [31:0] pick_addr();
    int r;
    logic [31:0] offs;
    r = $urandom_range(0, 99);
    offs = $urandom() & (FRAME_BYTES - 1);
    if (r < 70) return (32'($urandom_range(0, 255)) << bfa_pkg::PAGE_SHIFT) | offs;
    if (r < 85)
      return (32'($urandom_range(0, bfa_pkg::NUM_FRAMES - 1)) << bfa_pkg::PAGE_SHIFT) | offs;
    return $urandom();
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) allocs.note_request(opcode, address, end_address);
      if (out_valid && out_ready) begin
        allocs.check_reply(frame_address, status);
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // receiver stalls, with bursts of no stalling
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!rx_burst) stall_left <= idle_len();
    end
    if ($urandom_range(0, 299) == 0) rx_burst <= !rx_burst;
  end

  task automatic send_item(input logic [2:0] op, input logic [31:0] addr,
                           input logic [31:0] end_addr);
    int gap;
    gap = tx_burst ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    address <= addr;
    end_address <= end_addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // drop valid and hold until every reply is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
  endtask

  task automatic send_random_item();
    int r, k;
    logic [2:0] op;
    logic [31:0] a, e;
    r = $urandom_range(0, 99);
    a = pick_addr();
    e = $urandom();
    if (r < 30) begin
      op = bfa_pkg::OP_ALLOC;
    end else if (r < 50) begin
      op = bfa_pkg::OP_FREE;
    end else if (r < 70) begin
      op = bfa_pkg::OP_MARK;
    end else if (r < 86) begin
      op = bfa_pkg::OP_REGION;
      k = $urandom_range(0, 99);
      if (k < 75) begin
        e = a + 32'($urandom_range(0, 3)) * GROUP_BYTES + ($urandom() & (GROUP_BYTES - 1));
      end else if (k < 85) begin
        e = a - 32'($urandom_range(1, 4)) * GROUP_BYTES;
      end else if (k < 95) begin
        e = pick_addr();
      end else begin
        // fills the whole map so that allocate runs dry
        a = $urandom() & (GROUP_BYTES - 1);
        e = LAST_ADDR - ($urandom() & (GROUP_BYTES - 1));
      end
    end else if (r < 91) begin
      op = bfa_pkg::OP_CLEAR;
    end else begin
      op = 3'($urandom_range(int'(bfa_pkg::OP_CLEAR) + 1, OPCODE_CODES - 1));
    end
    send_item(op, a, e);
  endtask

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    allocs = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_item(bfa_pkg::OP_ALLOC, '0, '0);
    send_item(bfa_pkg::OP_ALLOC, '0, '0);
    send_item(bfa_pkg::OP_FREE, 32'h0000_0FFF, '0);
    send_item(bfa_pkg::OP_FREE, '0, '0);
    send_item(bfa_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(bfa_pkg::OP_MARK, 32'(FRAME_BYTES), '0);
    send_item(bfa_pkg::OP_MARK, LAST_ADDR, '0);
    send_item(bfa_pkg::OP_MARK, LAST_ADDR + 32'd1, '0);
    send_item(bfa_pkg::OP_FREE, 32'hFFFF_FFFF, '0);
    send_item(bfa_pkg::OP_REGION, LAST_ADDR + 32'd1, '0);
    send_item(bfa_pkg::OP_REGION, '0, 32'hFFFF_FFFF);
    send_item(bfa_pkg::OP_REGION, 32'h0010_0000, '0);
    send_item(bfa_pkg::OP_REGION, GROUP_BYTES, GROUP_BYTES);
    for (int c = int'(bfa_pkg::OP_CLEAR) + 1; c < OPCODE_CODES; c++)
      send_item(3'(c), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(bfa_pkg::OP_REGION, '0, LAST_ADDR);
    send_item(bfa_pkg::OP_ALLOC, '0, '0);
    send_item(bfa_pkg::OP_FREE, LAST_ADDR, '0);
    send_item(bfa_pkg::OP_ALLOC, '0, '0);
    send_item(bfa_pkg::OP_ALLOC, '0, '0);
    send_item(bfa_pkg::OP_CLEAR, '0, '0);
    send_item(bfa_pkg::OP_ALLOC, '0, '0);
    send_item(bfa_pkg::OP_REGION, '0, '0);
    send_item(bfa_pkg::OP_ALLOC, '0, '0);

    // hold the sender until every reply is back
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 59) == 0) tx_burst = !tx_burst;
      if (i % 150 == 149) wait_drained();
      send_random_item();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (allocs.outstanding() != 0)
      $error("%0d results never arrived", allocs.outstanding());

    if (allocs.mismatches == 0 && allocs.outstanding() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
